// File: design/ogn3_pkg.sv
// ogn3_pkg: shared constants and codes for the octave gradient noise block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ogn3_pkg;

    // input operation codes
    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // configuration register indexes
    localparam int            CFG_IDX_W   = 3;
    localparam int            CFG_W       = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd4;

    // permutation table
    localparam int TABLE_SIZE = 256;
    localparam int TAB_AW     = $clog2(TABLE_SIZE);
    localparam int TAB_DW     = 8;

    // field widths
    localparam int COORD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int NOISE_W = 16;
    localparam int QUOT_W  = 17;

    // default for the top level parameter
    localparam int MAX_OCTAVES_DEF = 8;

endpackage

// File: design/ogn3_perm_ram.sv
// ogn3_perm_ram: 256 x 8 permutation table, one port, registered read
// depends on ogn3_pkg
`timescale 1ns / 1ps

module ogn3_perm_ram
    import ogn3_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [TAB_AW-1:0] addr,
    input  logic [TAB_DW-1:0] wdata,
    output logic [TAB_DW-1:0] rdata
);

    logic [TAB_DW-1:0] mem [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/ogn3_mul.sv
// ogn3_mul: shared signed by unsigned multiplier with a registered product
// depends on ogn3_pkg
`timescale 1ns / 1ps

module ogn3_mul
    import ogn3_pkg::*;
#(
    parameter int A_W = 27,
    parameter int B_W = 25
)
(
    input  logic                   clk,
    input  logic signed [A_W-1:0]  a,
    input  logic        [B_W-1:0]  b,
    output logic signed [A_W+B_W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= a * $signed({1'b0, b});
    end

endmodule

// File: design/ogn3_div.sv
// ogn3_div: restoring divider, one quotient bit per cycle
// depends on ogn3_pkg
`timescale 1ns / 1ps

module ogn3_div
    import ogn3_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 31
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              fit;

    assign fit = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(QUOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= numer;
            dsh_reg  <= NUM_W'(denom) << (QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fit)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], fit};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: design/octave_gradient_noise_3d.sv
// octave_gradient_noise_3d: 3d gradient noise summed over octaves, normalized to q0.16
// depends on ogn3_pkg, ogn3_perm_ram, ogn3_mul, ogn3_div
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------
//   input    | in_valid / in_stall       | op, table_index, table_value, coord_x/y/z
//   output   | out_valid / out_stall     | noise_value, dims_error
//   config   | cfg_write                 | cfg_index, cfg_data
//
// a table write leaves the block idle; an evaluation with a dimension error goes
// straight to the finish state; an evaluation of n octaves runs coordinate residue
// setup, then per octave table reads on the single ram port and arithmetic on the
// shared multiplier, then a divide
// reset is asynchronous, no clearing pass; the table must be loaded before use
// in_stall is high while an evaluation runs; a stalled result waits in the output
// register and only blocks the next evaluation from finishing
`timescale 1ns / 1ps

module octave_gradient_noise_3d
    import ogn3_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [TAB_AW-1:0]    table_index,
    input  logic [TAB_DW-1:0]    table_value,
    input  logic [COORD_W-1:0]   coord_x,
    input  logic [COORD_W-1:0]   coord_y,
    input  logic [COORD_W-1:0]   coord_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NOISE_W-1:0]   noise_value,
    output logic                 dims_error,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int AMP_W = 17 + MAX_OCTAVES;
    localparam int SUM_W = AMP_W + 5;
    localparam int MA_W  = AMP_W + 2;
    localparam int MB_W  = AMP_W;
    localparam int PW    = MA_W + MB_W;
    localparam int TOT_W = AMP_W + 24;
    localparam int DIV_W = TOT_W - 1;
    localparam int LW    = 20;
    localparam logic signed [LW-1:0] ONE_L = LW'(1 << FRAC_W);
    localparam logic [4:0] PREP_LAST  = 5'd7;
    localparam logic [4:0] HASH_LAST  = 5'd14;
    localparam logic [4:0] ARITH_LAST = 5'd22;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_HASH,
        S_ARITH,
        S_DIV,
        S_FINISH
    } state_t;

    // configuration
    logic [3:0]  oct_cnt_reg;
    logic [16:0] pers_reg;
    logic [8:0]  per_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    // control
    state_t           state_reg;
    logic [4:0]       step_reg;
    logic [OCT_W-1:0] oct_reg;
    logic             out_valid_reg;
    logic [NOISE_W-1:0] noise_value_reg;
    logic             dims_error_reg;

    // datapath
    logic [COORD_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [8:0]         rx_reg, ry_reg, rz_reg;
    logic [7:0]         hr_reg [14];
    logic signed [LW-1:0] g_reg [8];
    logic signed [LW-1:0] d_reg [4];
    logic signed [LW-1:0] l_reg [4];
    logic signed [LW-1:0] dr0_reg, dr1_reg, m0_reg, m1_reg, n2_reg;
    logic [15:0]        t2_reg [3];
    logic [19:0]        q_reg  [3];
    logic [15:0]        t3_reg [3];
    logic [16:0]        fd_reg [3];
    logic [AMP_W-1:0]   amp_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic [NOISE_W-1:0] res_val_reg;
    logic               res_err_reg;

    logic               in_acc, out_free, dims_bad, last_oct;
    logic [OCT_W-1:0]   n_oct;
    logic [15:0]        fx, fy, fz;
    logic [7:0]         xi, yi, zi, xj, yj, zj;
    logic               ram_we;
    logic [TAB_AW-1:0]  ram_addr;
    logic [TAB_DW-1:0]  ram_rdata;
    logic signed [MA_W-1:0] mul_a;
    logic [MB_W-1:0]    mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] p_sh;
    logic [3:0]         hidx;
    logic               div_start, div_done;
    logic [QUOT_W-1:0]  div_quot;

    function automatic logic [8:0] feed_f(input logic [8:0] r, input logic b,
                                          input logic [8:0] per);
        logic [9:0] t;
        t = {r, b};
        if (per == 9'd0)
            return {1'b0, t[7:0]};
        else if (t >= {1'b0, per})
            return 9'(t - {1'b0, per});
        return t[8:0];
    endfunction

    // next lattice cell comes from the low byte of the wrapped cell
    function automatic logic [7:0] next_f(input logic [8:0] r, input logic [8:0] per);
        logic [8:0] s;
        s = {1'b0, r[7:0]} + 9'd1;
        if (per != 9'd0 && s == per)
            return 8'd0;
        return s[7:0];
    endfunction

    function automatic logic signed [LW-1:0] grad_f(input logic [3:0] h,
                                                    input logic signed [LW-1:0] x,
                                                    input logic signed [LW-1:0] y,
                                                    input logic signed [LW-1:0] z);
        logic signed [LW-1:0] u;
        logic signed [LW-1:0] v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // quadratic factor of the fade polynomial: 10*2^16 - 15f + (6*f*f >> 16)
    function automatic logic [19:0] q_f(input logic [31:0] ff, input logic [15:0] f);
        logic [34:0] s6;
        logic [21:0] q;
        s6 = {1'b0, ff, 2'b00} + {2'b00, ff, 1'b0};
        q  = 22'd655360 + 22'(s6[34:16]) - 22'(f) * 22'd15;
        return q[19:0];
    endfunction

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign dims_bad = (width_reg == 13'd0) || (height_reg == 13'd0);
    assign in_stall = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;
    assign dims_error  = dims_error_reg;

    always_comb
    begin
        if (oct_cnt_reg == 4'd0)
            n_oct = OCT_W'(1);
        else if (32'(oct_cnt_reg) > MAX_OCTAVES)
            n_oct = OCT_W'(MAX_OCTAVES);
        else
            n_oct = OCT_W'(oct_cnt_reg);
    end

    assign last_oct = ({1'b0, oct_reg} + 1'b1) == {1'b0, n_oct};

    assign fx = sx_reg[COORD_W-1 -: FRAC_W];
    assign fy = sy_reg[COORD_W-1 -: FRAC_W];
    assign fz = sz_reg[COORD_W-1 -: FRAC_W];
    assign xi = rx_reg[7:0];
    assign yi = ry_reg[7:0];
    assign zi = rz_reg[7:0];
    assign xj = next_f(rx_reg, per_reg);
    assign yj = next_f(ry_reg, per_reg);
    assign zj = next_f(rz_reg, per_reg);

    // table port: writes while idle, hash chain reads during the hash phase
    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = table_index;
        if (state_reg == S_IDLE)
        begin
            ram_we = in_acc && (op == OP_TABLE);
        end
        else
        begin
            unique case (step_reg)
                5'd0:    ram_addr = xi;
                5'd1:    ram_addr = xj;
                5'd2:    ram_addr = hr_reg[0] + yi;
                5'd3:    ram_addr = hr_reg[0] + yj;
                5'd4:    ram_addr = hr_reg[1] + yi;
                5'd5:    ram_addr = hr_reg[1] + yj;
                5'd6:    ram_addr = hr_reg[2] + zi;
                5'd7:    ram_addr = hr_reg[2] + zj;
                5'd8:    ram_addr = hr_reg[3] + zi;
                5'd9:    ram_addr = hr_reg[3] + zj;
                5'd10:   ram_addr = hr_reg[4] + zi;
                5'd11:   ram_addr = hr_reg[4] + zj;
                5'd12:   ram_addr = hr_reg[5] + zi;
                5'd13:   ram_addr = hr_reg[5] + zj;
                default: ram_addr = xi;
            endcase
        end
    end

    assign hidx = step_reg[3:0] - 4'd1;

    // shared multiplier operand schedule
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_ARITH)
        begin
            unique case (step_reg)
                5'd0:  begin mul_a = MA_W'({1'b0, fx}); mul_b = MB_W'(fx); end
                5'd1:  begin mul_a = MA_W'({1'b0, fy}); mul_b = MB_W'(fy); end
                5'd2:  begin mul_a = MA_W'({1'b0, fz}); mul_b = MB_W'(fz); end
                5'd3:  begin mul_a = MA_W'({1'b0, t2_reg[0]}); mul_b = MB_W'(fx); end
                5'd4:  begin mul_a = MA_W'({1'b0, t2_reg[1]}); mul_b = MB_W'(fy); end
                5'd5:  begin mul_a = MA_W'({1'b0, t2_reg[2]}); mul_b = MB_W'(fz); end
                5'd6:  begin mul_a = MA_W'({1'b0, q_reg[0]}); mul_b = MB_W'(t3_reg[0]); end
                5'd7:  begin mul_a = MA_W'({1'b0, q_reg[1]}); mul_b = MB_W'(t3_reg[1]); end
                5'd8:  begin mul_a = MA_W'({1'b0, q_reg[2]}); mul_b = MB_W'(t3_reg[2]); end
                5'd9:  begin mul_a = MA_W'(d_reg[0]); mul_b = MB_W'(fd_reg[0]); end
                5'd10: begin mul_a = MA_W'(d_reg[1]); mul_b = MB_W'(fd_reg[0]); end
                5'd11: begin mul_a = MA_W'(d_reg[2]); mul_b = MB_W'(fd_reg[0]); end
                5'd12: begin mul_a = MA_W'(d_reg[3]); mul_b = MB_W'(fd_reg[0]); end
                5'd14: begin mul_a = MA_W'(dr0_reg); mul_b = MB_W'(fd_reg[1]); end
                5'd15: begin mul_a = MA_W'(dr1_reg); mul_b = MB_W'(fd_reg[1]); end
                5'd18: begin mul_a = MA_W'(dr0_reg); mul_b = MB_W'(fd_reg[2]); end
                5'd20: begin mul_a = MA_W'(n2_reg); mul_b = amp_reg; end
                5'd21: begin mul_a = MA_W'({1'b0, pers_reg}); mul_b = amp_reg; end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign p_sh = mul_p >>> FRAC_W;

    assign div_start = (state_reg == S_DIV) && (step_reg == 5'd0) && (total_reg > 0);

    ogn3_perm_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (table_value),
        .rdata (ram_rdata)
    );

    ogn3_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ogn3_div #(
        .NUM_W (DIV_W),
        .DEN_W (SUM_W + 1)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (DIV_W'(total_reg)),
        .denom ({sum_reg, 1'b0}),
        .done  (div_done),
        .quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_cnt_reg <= 4'd1;
            pers_reg    <= 17'd32768;
            per_reg     <= 9'd0;
            width_reg   <= 13'd0;
            height_reg  <= 13'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OCTAVES: oct_cnt_reg <= cfg_data[3:0];
                CFG_PERSIST: pers_reg    <= cfg_data[16:0];
                CFG_PERIOD:  per_reg     <= cfg_data[8:0];
                CFG_WIDTH:   width_reg   <= cfg_data[12:0];
                CFG_HEIGHT:  height_reg  <= cfg_data[12:0];
                default:     ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            oct_reg         <= '0;
            out_valid_reg   <= 1'b0;
            noise_value_reg <= '0;
            dims_error_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && op == OP_EVAL)
                    begin
                        step_reg  <= '0;
                        oct_reg   <= '0;
                        state_reg <= dims_bad ? S_FINISH : S_PREP;
                    end
                end
                S_PREP:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == PREP_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == HASH_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ARITH;
                    end
                end
                S_ARITH:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == ARITH_LAST)
                    begin
                        step_reg  <= '0;
                        oct_reg   <= oct_reg + 1'b1;
                        state_reg <= last_oct ? S_DIV : S_HASH;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == 5'd0)
                    begin
                        step_reg <= 5'd1;
                        if (total_reg <= 0)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else if (div_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        noise_value_reg <= res_val_reg;
                        dims_error_reg  <= res_err_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_acc && op == OP_EVAL)
        begin
            sx_reg      <= coord_x;
            sy_reg      <= coord_y;
            sz_reg      <= coord_z;
            rx_reg      <= '0;
            ry_reg      <= '0;
            rz_reg      <= '0;
            total_reg   <= '0;
            amp_reg     <= AMP_W'(1 << FRAC_W);
            sum_reg     <= '0;
            res_val_reg <= '0;
            res_err_reg <= 1'b1;
        end
        else if (state_reg == S_PREP || (state_reg == S_ARITH && step_reg == ARITH_LAST))
        begin
            // residue of the integer part mod the period, one coordinate bit a step
            sx_reg <= {sx_reg[COORD_W-2:0], 1'b0};
            sy_reg <= {sy_reg[COORD_W-2:0], 1'b0};
            sz_reg <= {sz_reg[COORD_W-2:0], 1'b0};
            rx_reg <= feed_f(rx_reg, sx_reg[COORD_W-1], per_reg);
            ry_reg <= feed_f(ry_reg, sy_reg[COORD_W-1], per_reg);
            rz_reg <= feed_f(rz_reg, sz_reg[COORD_W-1], per_reg);
        end

        if (state_reg == S_HASH && step_reg != 5'd0)
        begin
            hr_reg[hidx] <= ram_rdata;
        end

        if (state_reg == S_ARITH)
        begin
            unique case (step_reg)
                5'd0:
                begin
                    for (int c = 0; c < 8; c++)
                    begin
                        g_reg[c] <= grad_f(hr_reg[6 + c][3:0],
                                           LW'({1'b0, fx}) - (c[2] ? ONE_L : '0),
                                           LW'({1'b0, fy}) - (c[1] ? ONE_L : '0),
                                           LW'({1'b0, fz}) - (c[0] ? ONE_L : '0));
                    end
                end
                5'd1:
                begin
                    t2_reg[0] <= mul_p[31:16];
                    q_reg[0]  <= q_f(mul_p[31:0], fx);
                    for (int j = 0; j < 4; j++)
                    begin
                        d_reg[j] <= g_reg[4 + j] - g_reg[j];
                    end
                end
                5'd2:
                begin
                    t2_reg[1] <= mul_p[31:16];
                    q_reg[1]  <= q_f(mul_p[31:0], fy);
                end
                5'd3:
                begin
                    t2_reg[2] <= mul_p[31:16];
                    q_reg[2]  <= q_f(mul_p[31:0], fz);
                end
                5'd4:  t3_reg[0] <= mul_p[31:16];
                5'd5:  t3_reg[1] <= mul_p[31:16];
                5'd6:  t3_reg[2] <= mul_p[31:16];
                5'd7:  fd_reg[0] <= mul_p[32:16];
                5'd8:  fd_reg[1] <= mul_p[32:16];
                5'd9:  fd_reg[2] <= mul_p[32:16];
                5'd10: l_reg[0] <= g_reg[0] + LW'(p_sh);
                5'd11: l_reg[1] <= g_reg[1] + LW'(p_sh);
                5'd12: l_reg[2] <= g_reg[2] + LW'(p_sh);
                5'd13:
                begin
                    l_reg[3] <= g_reg[3] + LW'(p_sh);
                    dr0_reg  <= l_reg[2] - l_reg[0];
                end
                5'd14: dr1_reg <= l_reg[3] - l_reg[1];
                5'd15: m0_reg  <= l_reg[0] + LW'(p_sh);
                5'd16: m1_reg  <= l_reg[1] + LW'(p_sh);
                5'd17: dr0_reg <= m1_reg - m0_reg;
                5'd19: n2_reg  <= m0_reg + LW'(p_sh) + ONE_L;
                5'd21: total_reg <= total_reg + TOT_W'(mul_p);
                5'd22:
                begin
                    amp_reg <= mul_p[AMP_W+FRAC_W-1:FRAC_W];
                    sum_reg <= sum_reg + SUM_W'(amp_reg);
                end
                default: ;
            endcase
        end

        if (state_reg == S_DIV && step_reg == 5'd0 && total_reg <= 0)
        begin
            res_val_reg <= '0;
            res_err_reg <= 1'b0;
        end
        else if (state_reg == S_DIV && div_done)
        begin
            res_val_reg <= div_quot[QUOT_W-1] ? '1 : div_quot[NOISE_W-1:0];
            res_err_reg <= 1'b0;
        end
    end

endmodule

// File: design/ogn3_checker.sv
// ogn3_checker: port-level assertions for octave_gradient_noise_3d, bound to the top
// depends on ogn3_pkg and octave_gradient_noise_3d
`timescale 1ns / 1ps

module ogn3_checker
    import ogn3_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               op,
    input logic               out_valid,
    input logic               out_stall,
    input logic [NOISE_W-1:0] noise_value,
    input logic               dims_error
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(noise_value) && $stable(dims_error))
        else $error("stalled result changed or dropped");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dims_error |-> noise_value == '0)
        else $error("error result with nonzero value");

    // an accepted evaluate transaction leaves the block busy in the following cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_EVAL |=> in_stall)
        else $error("block ready right after an evaluate");

    // a table write completes in its own cycle
    a_table_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_TABLE |=> !in_stall)
        else $error("block busy after a table write");

endmodule

bind octave_gradient_noise_3d ogn3_checker u_ogn3_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value),
    .dims_error  (dims_error)
);

// File: test/octave_gradient_noise_3d_tb.sv
// octave_gradient_noise_3d_tb: self-checking bench for the octave gradient noise block
// depends on ogn3_pkg and octave_gradient_noise_3d; predicts each result in fixed point
`timescale 1ns / 1ps

module octave_gradient_noise_3d_tb;
    import ogn3_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct {
        logic               op;
        logic [TAB_AW-1:0]  idx;
        logic [TAB_DW-1:0]  val;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } noise_req_t;

    typedef struct {
        logic [NOISE_W-1:0] noise;
        logic               err;
    } noise_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 op;
    logic [TAB_AW-1:0]    table_index;
    logic [TAB_DW-1:0]    table_value;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COORD_W-1:0]   coord_z;
    logic                 out_valid;
    logic                 out_stall;
    logic [NOISE_W-1:0]   noise_value;
    logic                 dims_error;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    noise_req_t pending_reqs[$];
    noise_res_t expected_noise[$];
    int         idle_left;
    int         stall_left;
    int         mismatches;
    bit         no_idle;

    // predictor state
    logic [7:0]  perm_mirror [TABLE_SIZE];
    logic [3:0]  octaves_r;
    logic [16:0] persist_r;
    logic [8:0]  period_r;
    logic [12:0] width_r;
    logic [12:0] height_r;

    octave_gradient_noise_3d u_top (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint fade_q16(longint f);
        longint t2, t3, q;
        t2 = (f * f) >>> 16;
        t3 = (t2 * f) >>> 16;
        q  = ((64'sd10 <<< 32) + 6 * f * f - 15 * f * 65536) >>> 16;
        return (t3 * q) >>> 16;
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint t);
        longint p;
        p = (b - a) * t;
        if (p >= 0)
            return a + p / 65536;
        return a - ((-p + 65535) / 65536);
    endfunction

    function automatic longint grad_dot(longint h, longint x, longint y, longint z);
        longint u, v;
        h = h & 15;
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function automatic longint pt(longint i);
        return longint'(perm_mirror[i & 255]);
    endfunction

    function automatic longint wrap_cell(longint c);
        longint v;
        v = c + 1;
        if (period_r != 0)
            v = v % longint'(period_r);
        return v;
    endfunction

    // one octave, offset: lattice value + 1.0 in q.16
    function automatic longint octave_q16(longint cx, longint cy, longint cz);
        longint per, xi, yi, zi, xj, yj, zj, x0, y0, z0, x1, y1, z1;
        longint u, v, w, l1, l2, m1, m2;
        if (period_r != 0)
        begin
            per = longint'(period_r) <<< 16;
            cx = cx % per;
            cy = cy % per;
            cz = cz % per;
        end
        xi = (cx >>> 16) & 255;
        yi = (cy >>> 16) & 255;
        zi = (cz >>> 16) & 255;
        x0 = cx & 16'hFFFF;
        y0 = cy & 16'hFFFF;
        z0 = cz & 16'hFFFF;
        x1 = x0 - 65536;
        y1 = y0 - 65536;
        z1 = z0 - 65536;
        u = fade_q16(x0);
        v = fade_q16(y0);
        w = fade_q16(z0);
        xj = wrap_cell(xi);
        yj = wrap_cell(yi);
        zj = wrap_cell(zi);
        l1 = lerp_q16(grad_dot(pt(pt(pt(xi) + yi) + zi), x0, y0, z0),
                      grad_dot(pt(pt(pt(xj) + yi) + zi), x1, y0, z0), u);
        l2 = lerp_q16(grad_dot(pt(pt(pt(xi) + yj) + zi), x0, y1, z0),
                      grad_dot(pt(pt(pt(xj) + yj) + zi), x1, y1, z0), u);
        m1 = lerp_q16(l1, l2, v);
        l1 = lerp_q16(grad_dot(pt(pt(pt(xi) + yi) + zj), x0, y0, z1),
                      grad_dot(pt(pt(pt(xj) + yi) + zj), x1, y0, z1), u);
        l2 = lerp_q16(grad_dot(pt(pt(pt(xi) + yj) + zj), x0, y1, z1),
                      grad_dot(pt(pt(pt(xj) + yj) + zj), x1, y1, z1), u);
        m2 = lerp_q16(l1, l2, v);
        return lerp_q16(m1, m2, w) + 65536;
    endfunction

    function automatic noise_res_t fractal_noise(noise_req_t r);
        noise_res_t res;
        longint total, amp, amp_sum, q;
        int n;
        res.noise = '0;
        res.err   = 1'b0;
        if (width_r == 0 || height_r == 0)
        begin
            res.err = 1'b1;
            return res;
        end
        n = (octaves_r == 0) ? 1 : ((octaves_r > 8) ? 8 : int'(octaves_r));
        total = 0;
        amp = 65536;
        amp_sum = 0;
        for (int i = 0; i < n; i++)
        begin
            total += octave_q16(longint'(r.x) <<< i, longint'(r.y) <<< i,
                                longint'(r.z) <<< i) * amp;
            amp_sum += amp;
            amp = (amp * longint'(persist_r)) >>> 16;
        end
        if (total > 0)
        begin
            q = total / (2 * amp_sum);
            res.noise = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        return res;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        int left;
        logic go;
        noise_req_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= OP_TABLE;
            table_index <= '0;
            table_value <= '0;
            coord_x     <= '0;
            coord_y     <= '0;
            coord_z     <= '0;
            idle_left   <= 0;
        end
        else
        begin
            left = idle_left;
            go = in_valid;
            if (in_valid && !in_stall)
            begin
                if (op == OP_EVAL)
                    expected_noise.push_back(fractal_noise('{op, table_index, table_value,
                                                             coord_x, coord_y, coord_z}));
                else
                    perm_mirror[table_index] = table_value;
                go = 1'b0;
                left = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (!go)
            begin
                if (left > 0)
                    left--;
                else if (pending_reqs.size() > 0)
                begin
                    nxt = pending_reqs.pop_front();
                    op          <= nxt.op;
                    table_index <= nxt.idx;
                    table_value <= nxt.val;
                    coord_x     <= nxt.x;
                    coord_y     <= nxt.y;
                    coord_z     <= nxt.z;
                    go = 1'b1;
                end
            end
            in_valid  <= go;
            idle_left <= left;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        int s;
        noise_res_t exp_r;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            s = stall_left;
            if (out_valid && !out_stall)
            begin
                if (expected_noise.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: noise %0d err %0d",
                                 noise_value, dims_error);
                end
                else
                begin
                    exp_r = expected_noise.pop_front();
                    if (exp_r.noise !== noise_value || exp_r.err !== dims_error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected noise %0d err %0d, got %0d err %0d",
                                     exp_r.noise, exp_r.err, noise_value, dims_error);
                    end
                end
                s = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (s > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= s - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_noise.size() > 0)
            @(posedge clk);
        // table writes give no result, allow the block to settle
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_OCTAVES: octaves_r = data[3:0];
            CFG_PERSIST: persist_r = data[16:0];
            CFG_PERIOD:  period_r  = data[8:0];
            CFG_WIDTH:   width_r   = data[12:0];
            CFG_HEIGHT:  height_r  = data[12:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(int oct, int pers, int per, int w, int h);
        wait_drained();
        write_reg(CFG_OCTAVES, CFG_W'(oct));
        write_reg(CFG_PERSIST, CFG_W'(pers));
        write_reg(CFG_PERIOD, CFG_W'(per));
        write_reg(CFG_WIDTH, CFG_W'(w));
        write_reg(CFG_HEIGHT, CFG_W'(h));
    endtask

    task automatic push_eval(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
        pending_reqs.push_back('{OP_EVAL, TAB_AW'($urandom()), TAB_DW'($urandom()),
                                 x, y, z});
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_reqs.push_back('{OP_TABLE, TAB_AW'($urandom()), TAB_DW'($urandom()),
                                         COORD_W'($urandom()), COORD_W'($urandom()),
                                         COORD_W'($urandom())});
            else if ($urandom_range(0, 3) == 0)
                push_eval(COORD_W'($urandom_range(0, 24'h03FFFF)),
                          COORD_W'($urandom_range(0, 24'h03FFFF)),
                          COORD_W'($urandom_range(0, 24'h03FFFF)));
            else
                push_eval(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
        end
    endtask

    initial
    begin
        int shuf [TABLE_SIZE];
        int j, tmp;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        no_idle    = 1'b0;
        octaves_r  = 4'd1;
        persist_r  = 17'd32768;
        period_r   = '0;
        width_r    = '0;
        height_r   = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
            perm_mirror[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dims are zero: every evaluation flags an error
        push_eval('0, '0, '0);
        push_eval('1, '1, '1);
        push_eval(24'h123456, 24'h00FFFF, 24'hFF0000);

        // load a shuffled table holding every value from 0 to 255
        for (int i = 0; i < TABLE_SIZE; i++)
            shuf[i] = i;
        for (int i = TABLE_SIZE - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = shuf[i];
            shuf[i] = shuf[j];
            shuf[j] = tmp;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
            pending_reqs.push_back('{OP_TABLE, TAB_AW'(i), TAB_DW'(shuf[i]), '0, '0, '0});

        // one dimension zero still gives the error
        set_regs(1, 32768, 0, 4096, 0);
        push_eval(24'h010000, 24'h020000, 24'h030000);
        set_regs(1, 32768, 0, 0, 1);
        push_eval(24'h010000, 24'h020000, 24'h030000);
        // spare register index is ignored
        wait_drained();
        write_reg(CFG_SPARE, '1);

        set_regs(8, 65536, 0, 4096, 4096);
        push_eval('0, '0, '0);
        push_eval('1, '1, '1);
        push_eval(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
        push_eval(24'hFF0000, 24'h000000, 24'hFF8000);
        push_eval(24'h008000, 24'h7F4000, 24'h80C000);
        push_eval(24'hAAAAAA, 24'h555555, 24'h0F0F0F);

        // octave count zero acts as one, period of one folds every lattice
        set_regs(0, 0, 1, 1, 1);
        push_eval(24'h00C000, 24'h014000, 24'hFFFFFF);
        push_eval(24'h123456, 24'h654321, 24'h000001);

        // octave count above the maximum saturates, full period
        set_regs(15, 65535, 256, 1, 4096);
        push_eval(24'hFFFFFF, 24'h000001, 24'h7FFFFF);
        push_eval(24'h00FFFF, 24'hFF0001, 24'h800000);

        set_regs(3, 40000, 17, 640, 480);
        push_eval(24'h10FFFF, 24'h110000, 24'h220000);
        push_random(60);

        // full speed stretch on both sides
        wait_drained();
        no_idle = 1'b1;
        push_random(30);
        wait_drained();
        no_idle = 1'b0;

        set_regs(1, 32768, 0, 2, 3);
        push_random(60);
        set_regs(8, 65536, 256, 4096, 4096);
        push_random(50);
        set_regs(5, 0, 3, 100, 7);
        push_random(40);
        set_regs(2, 20000, 200, 1, 1);
        push_random(40);

        wait_drained();
        if (mismatches == 0)
            $display("octave_gradient_noise_3d_tb: clean");
        else
            $display("octave_gradient_noise_3d_tb: errors");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("octave_gradient_noise_3d_tb: errors");
        $finish;
    end

endmodule
